// ===== rtl/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int RND_STG   = DIV_W + 1;
    localparam int SAT_STG   = DIV_W + 2;
    localparam int NUM_STG   = DIV_W + 3;

    localparam logic [2*DATA_W-1:0] HALF_LSB = (2*DATA_W)'(1) << (FRAC_BITS - 1);
    localparam logic [2*DATA_W-1:0] POS_MAX  = {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic [2*DATA_W-1:0] NEG_MAG  = {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MIN = 3'd4,
        OP_MAX = 3'd5,
        OP_INC = 3'd6,
        OP_DEC = 3'd7
    } t_op;

    // rem and res pair up as a 64-bit magnitude for multiply and after rounding
    typedef struct packed {
        t_op               op;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              neg;
        logic              dz;
        logic              sat;
        logic [DATA_W-1:0] dvs;
        logic [DIV_W-1:0]  num;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] res;
    } t_stage;

endpackage

// ===== rtl/fpa_div_step.sv =====
// One restoring division step: shifts in one dividend bit and yields one quotient bit.
// Depends on fpa_pkg for the data width.
`timescale 1ns / 1ps

module fpa_div_step (
    input  logic [fpa_pkg::DATA_W-1:0] i_rem,
    input  logic                       i_bit,
    input  logic [fpa_pkg::DATA_W-1:0] i_dvs,
    output logic [fpa_pkg::DATA_W-1:0] o_rem,
    output logic                       o_q
);
    import fpa_pkg::*;

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;

    always_comb begin
        shifted = {i_rem, i_bit};
        diff    = shifted - {1'b0, i_dvs};
        o_q     = (shifted >= {1'b0, i_dvs});
        o_rem   = o_q ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    end

endmodule

// ===== rtl/fixed_point_alu_top.sv =====
// Top level of the Q24.8 fixed-point ALU: operand prep, multiply, divider stages, saturation.
// Depends on fpa_pkg and fpa_div_step.
`timescale 1ns / 1ps

// Takes one request per cycle while o_stall is low and returns one Q24.8 result per
// request, in order. The restoring divider resolves one quotient bit per pipeline
// stage over 32 + FRAC_BITS stages; every operation travels the same stages so order
// is kept. Stages with no valid item close up behind a stalled output, so input
// transfers go on until the pipeline is full. Multiply and divide round half away
// from zero and saturate; a divide by zero returns 0 with its flag set.
module fixed_point_alu_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_req_type,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fpa_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_a_greater,
    output logic                              o_divide_by_zero,
    output logic                              o_saturated
);
    import fpa_pkg::*;

    t_stage r_stg [NUM_STG];
    t_stage n_stg [NUM_STG];
    logic   r_vld [NUM_STG];
    logic   en    [NUM_STG];

    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    t_op               in_op;

    // operand prep
    always_comb begin
        in_op = t_op'(i_req_type);
        mag_a = i_operand_a[DATA_W-1] ? (~i_operand_a + DATA_W'(1)) : i_operand_a;
        mag_b = i_operand_b[DATA_W-1] ? (~i_operand_b + DATA_W'(1)) : i_operand_b;

        n_stg[0].op  = in_op;
        n_stg[0].lt  = (i_operand_a < i_operand_b);
        n_stg[0].eq  = (i_operand_a == i_operand_b);
        n_stg[0].gt  = (i_operand_a > i_operand_b);
        n_stg[0].neg = i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
        n_stg[0].dz  = (in_op == OP_DIV) && (i_operand_b == '0);
        n_stg[0].sat = 1'b0;
        n_stg[0].dvs = mag_b;
        n_stg[0].num = (in_op == OP_DIV) ? {mag_a, {FRAC_BITS{1'b0}}}
                                         : {{FRAC_BITS{1'b0}}, mag_a};
        n_stg[0].rem = '0;

        case (in_op)
            OP_ADD:  n_stg[0].res = i_operand_a + i_operand_b;
            OP_SUB:  n_stg[0].res = i_operand_a - i_operand_b;
            OP_MIN:  n_stg[0].res = (i_operand_a < i_operand_b) ? i_operand_a : i_operand_b;
            OP_MAX:  n_stg[0].res = (i_operand_a > i_operand_b) ? i_operand_a : i_operand_b;
            OP_INC:  n_stg[0].res = i_operand_a + DATA_W'(1);
            OP_DEC:  n_stg[0].res = i_operand_a - DATA_W'(1);
            default: n_stg[0].res = '0;
        endcase
    end

    // divider stages; stages 1 and 2 also hold the multiply and its rounding
    for (genvar k = 1; k <= DIV_W; k++) begin : g_div
        logic [DATA_W-1:0]   step_rem;
        logic                step_q;
        logic [2*DATA_W-1:0] prod;
        logic [2*DATA_W-1:0] mag;

        fpa_div_step u_step (
            .i_rem (r_stg[k-1].rem),
            .i_bit (r_stg[k-1].num[DIV_W-1]),
            .i_dvs (r_stg[k-1].dvs),
            .o_rem (step_rem),
            .o_q   (step_q)
        );

        always_comb begin
            n_stg[k] = r_stg[k-1];
            prod     = '0;
            mag      = '0;
            if (r_stg[k-1].op == OP_DIV) begin
                n_stg[k].rem = step_rem;
                n_stg[k].num = {r_stg[k-1].num[DIV_W-2:0], step_q};
            end
            if (k == 1 && r_stg[k-1].op == OP_MUL) begin
                prod = {{DATA_W{1'b0}}, r_stg[k-1].num[DATA_W-1:0]} *
                       {{DATA_W{1'b0}}, r_stg[k-1].dvs};
                {n_stg[k].rem, n_stg[k].res} = prod;
            end
            if (k == 2 && r_stg[k-1].op == OP_MUL) begin
                mag = ({r_stg[k-1].rem, r_stg[k-1].res} + HALF_LSB) >> FRAC_BITS;
                {n_stg[k].rem, n_stg[k].res} = mag;
            end
        end
    end

    // quotient rounding: add one when twice the remainder reaches the divisor
    logic                rnd_up;
    logic [2*DATA_W-1:0] quo;

    always_comb begin
        n_stg[RND_STG] = r_stg[RND_STG-1];
        rnd_up = ({r_stg[RND_STG-1].rem, 1'b0} >= {1'b0, r_stg[RND_STG-1].dvs});
        quo    = {{(2*DATA_W-DIV_W){1'b0}}, r_stg[RND_STG-1].num} +
                 {{(2*DATA_W-1){1'b0}}, rnd_up};
        if (r_stg[RND_STG-1].op == OP_DIV) begin
            {n_stg[RND_STG].rem, n_stg[RND_STG].res} = quo;
        end
    end

    // sign and saturation
    logic [2*DATA_W-1:0] fin_mag;
    logic [DATA_W-1:0]   fin_neg;

    always_comb begin
        n_stg[SAT_STG] = r_stg[SAT_STG-1];
        fin_mag = {r_stg[SAT_STG-1].rem, r_stg[SAT_STG-1].res};
        fin_neg = ~r_stg[SAT_STG-1].res + DATA_W'(1);
        if (r_stg[SAT_STG-1].op == OP_MUL || r_stg[SAT_STG-1].op == OP_DIV) begin
            if (r_stg[SAT_STG-1].dz) begin
                n_stg[SAT_STG].res = '0;
            end else if (r_stg[SAT_STG-1].neg) begin
                if (fin_mag > NEG_MAG) begin
                    n_stg[SAT_STG].res = NEG_MAG[DATA_W-1:0];
                    n_stg[SAT_STG].sat = 1'b1;
                end else begin
                    n_stg[SAT_STG].res = fin_neg;
                end
            end else begin
                if (fin_mag > POS_MAX) begin
                    n_stg[SAT_STG].res = POS_MAX[DATA_W-1:0];
                    n_stg[SAT_STG].sat = 1'b1;
                end else begin
                    n_stg[SAT_STG].res = fin_mag[DATA_W-1:0];
                end
            end
        end
    end

    // empty stages close up behind a stalled output
    assign en[NUM_STG-1] = !r_vld[NUM_STG-1] || !i_stall;
    for (genvar k = 0; k < NUM_STG - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    for (genvar k = 0; k < NUM_STG; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_stall          = !en[0];
    assign o_valid          = r_vld[NUM_STG-1];
    assign o_result_value   = r_stg[NUM_STG-1].res;
    assign o_a_less         = r_stg[NUM_STG-1].lt;
    assign o_a_equal        = r_stg[NUM_STG-1].eq;
    assign o_a_greater      = r_stg[NUM_STG-1].gt;
    assign o_divide_by_zero = r_stg[NUM_STG-1].dz;
    assign o_saturated      = r_stg[NUM_STG-1].sat;

    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
        else $error("compare flags not exclusive");

    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result_value == '0 && !o_saturated))
        else $error("divide by zero result not cleared");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_result_value == POS_MAX[DATA_W-1:0] ||
             o_result_value == NEG_MAG[DATA_W-1:0]))
        else $error("saturated result not at a range limit");

    a_entry_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transfer not captured");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld[0] && r_vld[NUM_STG-1] && i_stall))
        else $error("input stalled with room in the pipeline");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for fixed_point_alu_top: directed table, then random requests.
// Expected results are typed in or come from an in-bench Q24.8 predictor; depends on fpa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int          ITEMS_RANDOM = 1125;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 60;
    localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] Q_ONE        = 32'h1 << FRAC_BITS;

    typedef struct packed {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        sat;
    } t_alu_outcome;

    typedef struct packed {
        t_op          op;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         typed;
        t_alu_outcome want;
    } t_alu_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result_value;
    logic               o_a_less;
    logic               o_a_equal;
    logic               o_a_greater;
    logic               o_divide_by_zero;
    logic               o_saturated;

    t_alu_outcome pending_results[$];
    t_alu_outcome oldest;
    int           errors = 0;
    int           cycles = 0;
    bit           steady = 1'b0;

    // value, lt, eq, gt, dz, sat typed in where obvious
    t_alu_row directed_rows [25] = '{
        '{OP_ADD, Q_MAX, 32'h1, 1'b1, '{Q_MIN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_SUB, Q_MIN, 32'h1, 1'b1, '{Q_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{OP_MUL, Q_ONE, Q_ONE, 1'b1, '{Q_ONE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{OP_MUL, Q_MAX, Q_MAX, 1'b1, '{Q_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{OP_MUL, Q_MIN, Q_MAX, 1'b1, '{Q_MIN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{OP_MUL, Q_MIN, Q_MIN, 1'b1, '{Q_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{OP_MUL, 32'h1, 32'h80, 1'b0, '0},
        '{OP_MUL, 32'hffff_ffff, 32'h80, 1'b0, '0},
        '{OP_DIV, Q_ONE, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{OP_DIV, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{OP_DIV, Q_MIN, 32'h0, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{OP_DIV, Q_MAX, 32'h1, 1'b1, '{Q_MAX, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{OP_DIV, Q_MIN, 32'hffff_ffff, 1'b1, '{Q_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{OP_DIV, Q_ONE, 32'h300, 1'b0, '0},
        '{OP_DIV, 32'hffff_ff00, 32'h200, 1'b0, '0},
        '{OP_MIN, 32'h5, 32'hffff_fffb, 1'b1, '{32'hffff_fffb, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_MAX, 32'h5, 32'hffff_fffb, 1'b1, '{32'h5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_MIN, 32'h7, 32'h7, 1'b1, '{32'h7, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{OP_MAX, Q_MIN, Q_MAX, 1'b1, '{Q_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{OP_INC, Q_MAX, 32'h0, 1'b1, '{Q_MIN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_DEC, Q_MIN, 32'h1234_5678, 1'b1, '{Q_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{OP_INC, 32'h0, Q_MIN, 1'b1, '{32'h1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_DEC, 32'h0, 32'h0, 1'b1, '{32'hffff_ffff, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
          '{32'hffff_fffe, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{OP_SUB, 32'h0, Q_MIN, 1'b1, '{Q_MIN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}}
    };

    fixed_point_alu_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_value   (o_result_value),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_a_greater      (o_a_greater),
        .o_divide_by_zero (o_divide_by_zero),
        .o_saturated      (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // signed saturation of a rounded magnitude
    function automatic logic [31:0] clip_q(input logic [63:0] mag, input logic neg,
                                           output logic sat);
        sat = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                sat = 1'b1;
                return Q_MIN;
            end
            return 32'h0 - mag[31:0];
        end
        if (mag > 64'h7fff_ffff) begin
            sat = 1'b1;
            return Q_MAX;
        end
        return mag[31:0];
    endfunction

    function automatic t_alu_outcome alu_predict(t_op op, logic signed [31:0] a,
                                                 logic signed [31:0] b);
        t_alu_outcome o;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  mag;
        logic         neg;
        o   = '0;
        ma  = {{32{a[31]}}, a};
        mb  = {{32{b[31]}}, b};
        if (a[31]) ma = 64'h0 - ma;
        if (b[31]) mb = 64'h0 - mb;
        neg = a[31] ^ b[31];
        case (op)
            OP_ADD: o.value = a + b;
            OP_SUB: o.value = a - b;
            OP_MUL: begin
                mag     = (ma * mb + (64'h1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                o.value = clip_q(mag, neg, o.sat);
            end
            OP_DIV: begin
                if (b == 0) begin
                    o.dz = 1'b1;
                end else begin
                    mag     = (64'd2 * (ma << FRAC_BITS) + mb) / (64'd2 * mb);
                    o.value = clip_q(mag, neg, o.sat);
                end
            end
            OP_MIN: o.value = (a < b) ? a : b;
            OP_MAX: o.value = (a > b) ? a : b;
            OP_INC: o.value = a + 32'sd1;
            default: o.value = a - 32'sd1;
        endcase
        o.lt = a < b;
        o.eq = a == b;
        o.gt = a > b;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(8191) - 32'd4096;
            7:          return Q_ONE * ($urandom_range(64) - 32'd32);
            8: begin
                case ($urandom_range(4))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return 32'h0;
                    3: return 32'hffff_ffff;
                    default: return 32'h1;
                endcase
            end
            default: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_request(t_op op, logic [31:0] a, logic [31:0] b, t_alu_outcome want);
        while (!steady && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 28);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transfer: result %0h", $time, o_result_value);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("result_value", oldest.value, o_result_value);
                check_field("a_less", oldest.lt, o_a_less);
                check_field("a_equal", oldest.eq, o_a_equal);
                check_field("a_greater", oldest.gt, o_a_greater);
                check_field("divide_by_zero", oldest.dz, o_divide_by_zero);
                check_field("saturated", oldest.sat, o_saturated);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("fixed_point_alu_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_req_type  = OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed ? directed_rows[i].want
                             : alu_predict(directed_rows[i].op, directed_rows[i].a,
                                           directed_rows[i].b));
        end

        for (int n = 0; n < ITEMS_RANDOM; n++) begin
            steady = (n >= 500 && n < 700);
            op     = t_op'($urandom_range(7));
            a      = pick_operand();
            case ($urandom_range(19))
                0, 1, 2: b = a;
                3:       b = 32'h0;
                default: b = pick_operand();
            endcase
            send_request(op, a, b, alu_predict(op, a, b));
        end
        steady  = 1'b0;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("fixed_point_alu_top: match");
        end else begin
            $display("fixed_point_alu_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== fixed_point_alu_top.f =====
rtl/fpa_pkg.sv
rtl/fpa_div_step.sv
rtl/fixed_point_alu_top.sv
dv/testbench.sv
